### rtl/rme_pkg.sv
// Shared constants and controller/datapath interface types for the modular exponentiation unit.
package rme_pkg;

	localparam int WIDTH_DEF = 32;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic start;      // capture the block, load the exponent shifter
		logic red_step;   // one bit of base reduction
		logic init_acc;   // accumulator = 1 mod m
		logic mul_load;   // clear product, load multiplier operand
		logic mul_sq;     // with mul_load: square (else multiply by base)
		logic mul_step;   // one bit of shift-and-add modular multiply
		logic mul_end;    // product into accumulator
		logic exp_shift;  // advance to the next exponent bit
		logic out_load;   // result into the output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic exp_zero;
		logic mod_zero;
		logic e_msb;
		logic out_free;
	} stat_t;

endpackage

### rtl/rsa_modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit: controller, datapath and port wiring.
// Each input transaction carries one block; the unit returns block^exponent mod modulus,
// with exponent and modulus taken from two configuration registers (index 0 exponent,
// reset 1; index 1 modulus, reset 2; other indexes ignored). The block is first reduced
// modulo the modulus one bit per cycle, then the exponent is scanned from its top bit
// down with left-to-right square-and-multiply; every modular multiply is a bit-serial
// shift-and-add done in one shared double-add-reduce unit, one multiplier bit per cycle.
// A zero exponent gives 1 and a zero modulus gives 0. One block is processed at a time;
// the output register lets the next block be accepted while the previous result still
// waits for out_ready. Configuration must be written only while no transaction is in
// flight.
module rsa_modular_exponentiation_unit #(
	parameter int WIDTH = rme_pkg::WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [rme_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [WIDTH-2:0]             wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [WIDTH-2:0]             block_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [WIDTH-2:0]             result_value
);
	import rme_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer: owns the loop counters and the square/multiply phase
	rme_ctrl #(
		.WIDTH (WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Arithmetic, configuration registers and the output register
	rme_datapath #(
		.WIDTH (WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.block_value  (block_value),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value)
	);

endmodule

### rtl/rme_datapath.sv
// Datapath: configuration registers, shift registers, modular step unit and output register.
module rme_datapath #(
	parameter int WIDTH = rme_pkg::WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [rme_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [WIDTH-2:0]             wr_data,
	input  logic [WIDTH-2:0]             block_value,
	input  rme_pkg::cmd_t                cmd,
	output rme_pkg::stat_t               stat,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [WIDTH-2:0]             result_value
);
	import rme_pkg::*;

	localparam int FW = WIDTH - 1;

	logic [FW-1:0] exp_q, mod_q;
	logic [FW-1:0] blk_sh_q, base_q, acc_q, prod_q, mb_sh_q, esh_q, res_q;
	logic          out_valid_q;

	logic [FW-1:0] sx, sadd, step_res;
	logic [FW+1:0] sum, m1, m2, red;

	// Shared step: (2x + addend) mod m, with x and addend below m
	always_comb begin
		if (cmd.red_step) begin
			sx   = base_q;
			sadd = FW'(blk_sh_q[FW-1]);
		end else begin
			sx   = prod_q;
			sadd = mb_sh_q[FW-1] ? acc_q : '0;
		end
		sum = {1'b0, sx, 1'b0} + {2'b00, sadd};
		m1  = {2'b00, mod_q};
		m2  = {1'b0, mod_q, 1'b0};
		if (sum >= m2) begin
			red = sum - m2;
		end else if (sum >= m1) begin
			red = sum - m1;
		end else begin
			red = sum;
		end
		step_res = red[FW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= FW'(1);
			mod_q <= FW'(2);
		end else if (wr_en) begin
			case (wr_index)
				REG_EXPONENT: exp_q <= wr_data;
				REG_MODULUS:  mod_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			blk_sh_q <= block_value;
			base_q   <= '0;
			esh_q    <= exp_q;
		end
		if (cmd.red_step) begin
			base_q   <= step_res;
			blk_sh_q <= {blk_sh_q[FW-2:0], 1'b0};
		end
		if (cmd.init_acc) begin
			acc_q <= (mod_q == FW'(1)) ? '0 : FW'(1);
		end
		if (cmd.mul_load) begin
			prod_q  <= '0;
			mb_sh_q <= cmd.mul_sq ? acc_q : base_q;
		end
		if (cmd.mul_step) begin
			prod_q  <= step_res;
			mb_sh_q <= {mb_sh_q[FW-2:0], 1'b0};
		end
		if (cmd.mul_end) begin
			acc_q <= prod_q;
		end
		if (cmd.exp_shift) begin
			esh_q <= {esh_q[FW-2:0], 1'b0};
		end
		if (cmd.out_load) begin
			if (exp_q == '0) begin
				res_q <= FW'(1);
			end else if (mod_q == '0) begin
				res_q <= '0;
			end else begin
				res_q <= acc_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.exp_zero = (exp_q == '0);
		stat.mod_zero = (mod_q == '0);
		stat.e_msb    = esh_q[FW-1];
		stat.out_free = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign result_value = res_q;

`ifndef SYNTH
	a_prod_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_step |-> (prod_q < mod_q))
		else $error("product accumulator not reduced");
	a_acc_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_load |-> (acc_q < mod_q))
		else $error("accumulator not reduced at multiply start");
`endif

endmodule

### rtl/rme_ctrl.sv
// Controller: sequences base reduction and square-and-multiply over the exponent bits.
module rme_ctrl #(
	parameter int WIDTH = rme_pkg::WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rme_pkg::stat_t stat,
	output rme_pkg::cmd_t  cmd
);
	import rme_pkg::*;

	localparam int FW = WIDTH - 1;
	localparam int CW = $clog2(FW);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RED   = 3'd1;
	localparam logic [2:0] ST_INIT  = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_MSTEP = 3'd4;
	localparam logic [2:0] ST_MEND  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;     // reduction and multiply bit count
	logic [CW-1:0] ecnt_q, ecnt_d;   // exponent bit count
	logic          sq_q, sq_d;       // next multiply is a square

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ecnt_d   = ecnt_q;
		sq_d     = sq_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					cnt_d     = CW'(FW - 1);
					if (stat.exp_zero || stat.mod_zero) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_RED;
					end
				end
			end
			ST_RED: begin
				cmd.red_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_INIT;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_INIT: begin
				cmd.init_acc = 1'b1;
				ecnt_d       = CW'(FW - 1);
				sq_d         = 1'b1;
				state_d      = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.mul_load = 1'b1;
				cmd.mul_sq   = sq_q;
				cnt_d        = CW'(FW - 1);
				state_d      = ST_MSTEP;
			end
			ST_MSTEP: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_MEND;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_MEND: begin
				cmd.mul_end = 1'b1;
				if (sq_q && stat.e_msb) begin
					sq_d    = 1'b0;
					state_d = ST_LOAD;
				end else begin
					cmd.exp_shift = 1'b1;
					sq_d          = 1'b1;
					if (ecnt_q == '0) begin
						state_d = ST_DONE;
					end else begin
						ecnt_d  = ecnt_q - 1'b1;
						state_d = ST_LOAD;
					end
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ecnt_q  <= '0;
			sq_q    <= 1'b1;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ecnt_q  <= ecnt_d;
			sq_q    <= sq_d;
		end
	end

`ifndef SYNTH
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("output register overwritten while occupied");
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.red_step, cmd.init_acc, cmd.mul_load, cmd.mul_step, cmd.mul_end}))
		else $error("conflicting datapath commands");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != ST_IDLE))
		else $error("controller idle right after accepting a transaction");
`endif

endmodule

### bench/modexp_checker.sv
// Checker for the modular exponentiation unit: tracks the key registers, predicts and compares results.
`timescale 1ns / 100ps
module modexp_checker #(
	parameter int WIDTH = rme_pkg::WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [rme_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [WIDTH-2:0]              wr_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [WIDTH-2:0]              block_value,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [WIDTH-2:0]              result_value,
	output int                            pending,
	output int                            errors
);
	import rme_pkg::*;

	typedef struct {
		logic [WIDTH-2:0] blk;
		logic [WIDTH-2:0] expo;
		logic [WIDTH-2:0] modu;
		logic [WIDTH-2:0] result;
	} power_job_t;

	power_job_t       due_results[$];
	power_job_t       job;
	logic [WIDTH-2:0] exp_reg;
	logic [WIDTH-2:0] mod_reg;

	// base^e mod m; a zero exponent gives 1 even for a modulus of zero or one
	function automatic logic [WIDTH-2:0] mod_power(input logic [WIDTH-2:0] base,
			input logic [WIDTH-2:0] e, input logic [WIDTH-2:0] m);
		logic [2*WIDTH-1:0] acc;
		logic [2*WIDTH-1:0] b;
		logic [2*WIDTH-1:0] mm;
		if (e == '0)
			return (WIDTH-1)'(1);
		if (m == '0)
			return '0;
		mm = (2*WIDTH)'(m);
		b = (2*WIDTH)'(base) % mm;
		acc = (2*WIDTH)'(1) % mm;
		for (int i = WIDTH - 2; i >= 0; i--) begin
			acc = (acc * acc) % mm;
			if (e[i])
				acc = (acc * b) % mm;
		end
		return acc[WIDTH-2:0];
	endfunction

	task automatic report_mismatch(input string detail);
		$display("%0t modexp_checker: %s", $time, detail);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_reg = 1;
			mod_reg = 2;
			errors = 0;
			due_results.delete();
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_EXPONENT: exp_reg = wr_data;
					REG_MODULUS:  mod_reg = wr_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				job.blk = block_value;
				job.expo = exp_reg;
				job.modu = mod_reg;
				job.result = mod_power(block_value, exp_reg, mod_reg);
				due_results.push_back(job);
			end
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing outstanding",
						result_value));
				end else begin
					job = due_results.pop_front();
					if (result_value !== job.result)
						report_mismatch($sformatf(
							"result_value: block %0d exp %0d mod %0d, want %0d got %0d",
							job.blk, job.expo, job.modu, job.result, result_value));
				end
			end
		end
		pending = due_results.size();
	end

endmodule

### bench/tb_top.sv
// Testbench top for the modular exponentiation unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
	import rme_pkg::*;

	localparam int W = WIDTH_DEF;
	localparam logic [W-2:0] FIELD_MAX = '1;
	localparam int BLOCK_COUNT = 255;
	// Covers the slowest block plus short output stalls and the final wait, many times over.
	localparam int STALL_LIMIT = 30000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = REG_EXPONENT;
	logic [W-2:0]         wr_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [W-2:0]         block_value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [W-2:0]         result_value;

	int pending;
	int errors;
	int idle_pct = 16;   // chance in a hundred that either side idles in a cycle
	int quiet_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	rsa_modular_exponentiation_unit #(.WIDTH(W)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.block_value  (block_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value)
	);

	modexp_checker #(.WIDTH(W)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.block_value  (block_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.pending      (pending),
		.errors       (errors)
	);

	// Receiver: stall at random, except during the steady stretch where idle_pct is zero.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// Watchdog: abort when no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	function automatic logic [W-2:0] rand_field();
		rand_field = (W-1)'($urandom());
	endfunction

	// Offer one block; called and returning at a falling edge. Valid drops only
	// for a random idle cycle, never between back-to-back transactions.
	task automatic send_block(input logic [W-2:0] value);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		block_value <= value;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Hold the sender until every outstanding result has come back, then settle.
	task automatic wait_results();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write both key registers while the unit is idle.
	task automatic load_key(input logic [W-2:0] key_exp, input logic [W-2:0] key_mod);
		wr_en <= 1'b1;
		wr_index <= REG_EXPONENT;
		wr_data <= key_exp;
		@(negedge clk);
		wr_index <= REG_MODULUS;
		wr_data <= key_mod;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin
		logic [W-2:0] key_exp;
		logic [W-2:0] key_mod;
		logic [W-2:0] blk;
		int           sent;
		int           batch;
		int           pick;

		sent = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset key (exponent 1, modulus 2): result is the block's low bit.
		send_block('0);
		send_block(1);
		send_block(FIELD_MAX);

		// Zero exponent gives 1 even with a modulus of one or zero.
		wait_results();
		load_key('0, 1);
		send_block('0);
		send_block('h5A5A5A5A);
		wait_results();
		load_key('0, '0);
		send_block(FIELD_MAX);

		// Largest exponent and modulus; a block equal to the modulus wraps first.
		wait_results();
		load_key(FIELD_MAX, FIELD_MAX);
		send_block('0);
		send_block(1);
		send_block(2);
		send_block(FIELD_MAX - 1'b1);
		send_block(FIELD_MAX);

		// Modulus of one with a nonzero exponent gives 0; modulus of zero gives 0.
		wait_results();
		load_key(7, 1);
		send_block(12345);
		wait_results();
		load_key(65537, '0);
		send_block(42);
		send_block(FIELD_MAX);

		// Textbook key pair: encrypt 65, then decrypt the ciphertext back.
		wait_results();
		load_key(17, 3233);
		send_block(65);
		send_block(3233 + 65);
		wait_results();
		load_key(2753, 3233);
		send_block(2790);
		wait_results();
		load_key(FIELD_MAX, 2);
		send_block(3);

		// Random keys, each followed by a batch of random blocks.
		while (sent < BLOCK_COUNT) begin
			pick = $urandom_range(99);
			if (pick < 8)
				key_exp = '0;
			else if (pick < 16)
				key_exp = FIELD_MAX;
			else if (pick < 30)
				key_exp = (W-1)'($urandom_range(255, 1));
			else
				key_exp = rand_field();

			pick = $urandom_range(99);
			if (pick < 5)
				key_mod = '0;
			else if (pick < 10)
				key_mod = 1;
			else if (pick < 15)
				key_mod = 2;
			else if (pick < 22)
				key_mod = FIELD_MAX;
			else if (pick < 40)
				key_mod = (W-1)'($urandom_range(65535, 3));
			else
				key_mod = rand_field();

			wait_results();
			load_key(key_exp, key_mod);

			batch = $urandom_range(30, 8);
			for (int k = 0; k < batch; k++) begin
				idle_pct = (sent >= 80 && sent < 140) ? 0 : 16;
				pick = $urandom_range(99);
				if (pick < 8)
					blk = '0;
				else if (pick < 16)
					blk = FIELD_MAX;
				else if (pick < 28 && key_mod != '0)
					blk = key_mod - 1'b1;
				else if (pick < 36)
					blk = key_mod;
				else
					blk = rand_field();
				send_block(blk);
				sent++;
				// Occasionally drain mid-batch so the unit restarts from empty.
				if (k == batch / 2 && $urandom_range(9) == 0)
					wait_results();
			end
		end

		wait_results();
		// Give a stray result time to show up.
		repeat (2200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
